FILE: rtl/core/obot_pkg.sv
// shared types and constants for the oriented box overlap test
package obot_pkg;
    // operand width of the shared multiplier (signed, covers a 33-bit center difference)
    localparam int MulW  = 33;
    localparam int ProdW = 2 * MulW;
    typedef logic signed [MulW-1:0]  t_mul_op;
    typedef logic signed [ProdW-1:0] t_mul_prod;
endpackage

FILE: rtl/core/obot_mul.sv
// shared signed multiplier with a registered product
module obot_mul (
    input  logic                i_clk,
    input  obot_pkg::t_mul_op   i_a,
    input  obot_pkg::t_mul_op   i_b,
    output obot_pkg::t_mul_prod o_prod
);
    obot_pkg::t_mul_prod r_prod;

    // one product per cycle, consumed the cycle after
    always_ff @(posedge i_clk) begin
        r_prod <= obot_pkg::t_mul_prod'(i_a) * obot_pkg::t_mul_prod'(i_b);
    end

    assign o_prod = r_prod;
endmodule

FILE: rtl/core/oriented_box_overlap_test.sv
// top level: 2d separating axis overlap test on one shared multiplier
//
// Input channel i_valid / o_stall carries one item per handshake. An item with
// i_func = 0 stores box A and gives no result; the block stays idle. An item
// with i_func = 1 carries box B and gives one o_overlaps result on o_valid /
// i_stall. Each of the four candidate axes (A1, A2, B1, B2) runs 14 multiply
// steps, each a multiply state followed by an accumulate state, then a compare;
// an axis of zero length is skipped. A test stops at the first separating axis.
// o_stall is high while a test runs and while a result waits; a stalled
// result holds on o_valid / o_overlaps until i_stall is low.
// Reset (i_rst_n low, synchronous) clears box A to a point at the origin with
// zero axes and drops any result in flight.
module oriented_box_overlap_test (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_func,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic signed [15:0] i_axis1_x,
    input  logic signed [15:0] i_axis1_y,
    input  logic signed [15:0] i_axis2_x,
    input  logic signed [15:0] i_axis2_y,
    input  logic        [30:0] i_half_len1,
    input  logic        [30:0] i_half_len2,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_overlaps
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_ACC   = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;

    localparam logic [3:0] OP_DX  = 4'd0;
    localparam logic [3:0] OP_DY  = 4'd1;
    localparam logic [3:0] OP_A1X = 4'd2;
    localparam logic [3:0] OP_A1Y = 4'd3;
    localparam logic [3:0] OP_HA1 = 4'd4;
    localparam logic [3:0] OP_A2X = 4'd5;
    localparam logic [3:0] OP_A2Y = 4'd6;
    localparam logic [3:0] OP_HA2 = 4'd7;
    localparam logic [3:0] OP_B1X = 4'd8;
    localparam logic [3:0] OP_B1Y = 4'd9;
    localparam logic [3:0] OP_HB1 = 4'd10;
    localparam logic [3:0] OP_B2X = 4'd11;
    localparam logic [3:0] OP_B2Y = 4'd12;
    localparam logic [3:0] OP_HB2 = 4'd13;

    localparam logic [1:0] AX_A1 = 2'd0;
    localparam logic [1:0] AX_A2 = 2'd1;
    localparam logic [1:0] AX_B1 = 2'd2;
    localparam logic [1:0] AX_B2 = 2'd3;

    localparam int DotW = 51;

    // box A (stored) and box B (current test)
    logic signed [31:0] r_a_cx, r_a_cy, r_b_cx, r_b_cy;
    logic signed [15:0] r_a_1x, r_a_1y, r_a_2x, r_a_2y;
    logic signed [15:0] r_b_1x, r_b_1y, r_b_2x, r_b_2y;
    logic        [30:0] r_a_h1, r_a_h2, r_b_h1, r_b_h2;

    logic [2:0] r_state;
    logic [1:0] r_axis;
    logic [3:0] r_op;
    logic signed [DotW-1:0] r_dot;
    logic [31:0] r_d;
    logic [63:0] r_sep;
    logic [64:0] r_reach;
    logic r_out_valid, r_overlaps;

    logic in_acc;
    logic signed [15:0] nx, ny;
    logic signed [32:0] dx, dy;
    obot_pkg::t_mul_op   mul_a, mul_b;
    obot_pkg::t_mul_prod prod;
    logic signed [DotW-1:0] dot_sum, dot_abs;

    assign o_stall    = (r_state != ST_IDLE) || r_out_valid;
    assign in_acc     = i_valid && !o_stall;
    assign o_valid    = r_out_valid;
    assign o_overlaps = r_overlaps;

    // box A and box B capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_cx <= '0; r_a_cy <= '0;
            r_a_1x <= '0; r_a_1y <= '0; r_a_2x <= '0; r_a_2y <= '0;
            r_a_h1 <= '0; r_a_h2 <= '0;
        end else if (in_acc && !i_func) begin
            r_a_cx <= i_center_x; r_a_cy <= i_center_y;
            r_a_1x <= i_axis1_x; r_a_1y <= i_axis1_y;
            r_a_2x <= i_axis2_x; r_a_2y <= i_axis2_y;
            r_a_h1 <= i_half_len1; r_a_h2 <= i_half_len2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_func) begin
            r_b_cx <= i_center_x; r_b_cy <= i_center_y;
            r_b_1x <= i_axis1_x; r_b_1y <= i_axis1_y;
            r_b_2x <= i_axis2_x; r_b_2y <= i_axis2_y;
            r_b_h1 <= i_half_len1; r_b_h2 <= i_half_len2;
        end
    end

    // candidate axis under test
    always_comb begin
        unique case (r_axis)
            AX_A1:   begin nx = r_a_1x; ny = r_a_1y; end
            AX_A2:   begin nx = r_a_2x; ny = r_a_2y; end
            AX_B1:   begin nx = r_b_1x; ny = r_b_1y; end
            AX_B2:   begin nx = r_b_2x; ny = r_b_2y; end
            default: begin nx = r_a_1x; ny = r_a_1y; end
        endcase
    end

    assign dx = 33'(r_a_cx) - 33'(r_b_cx);
    assign dy = 33'(r_a_cy) - 33'(r_b_cy);

    // multiplier operand select by step
    always_comb begin
        mul_a = dx;
        mul_b = 33'(nx);
        unique case (r_op)
            OP_DX:  begin mul_a = dx;           mul_b = 33'(nx); end
            OP_DY:  begin mul_a = dy;           mul_b = 33'(ny); end
            OP_A1X: begin mul_a = 33'(r_a_1x);  mul_b = 33'(nx); end
            OP_A1Y: begin mul_a = 33'(r_a_1y);  mul_b = 33'(ny); end
            OP_HA1: begin mul_a = {2'b00, r_a_h1}; mul_b = {1'b0, r_d}; end
            OP_A2X: begin mul_a = 33'(r_a_2x);  mul_b = 33'(nx); end
            OP_A2Y: begin mul_a = 33'(r_a_2y);  mul_b = 33'(ny); end
            OP_HA2: begin mul_a = {2'b00, r_a_h2}; mul_b = {1'b0, r_d}; end
            OP_B1X: begin mul_a = 33'(r_b_1x);  mul_b = 33'(nx); end
            OP_B1Y: begin mul_a = 33'(r_b_1y);  mul_b = 33'(ny); end
            OP_HB1: begin mul_a = {2'b00, r_b_h1}; mul_b = {1'b0, r_d}; end
            OP_B2X: begin mul_a = 33'(r_b_2x);  mul_b = 33'(nx); end
            OP_B2Y: begin mul_a = 33'(r_b_2y);  mul_b = 33'(ny); end
            OP_HB2: begin mul_a = {2'b00, r_b_h2}; mul_b = {1'b0, r_d}; end
            default: begin mul_a = dx;          mul_b = 33'(nx); end
        endcase
    end

    obot_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // closing a dot product: sum and magnitude
    assign dot_sum = r_dot + prod[DotW-1:0];
    assign dot_abs = dot_sum[DotW-1] ? -dot_sum : dot_sum;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_axis      <= AX_A1;
            r_op        <= OP_DX;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && i_func) begin
                        r_axis  <= AX_A1;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_op    <= OP_DX;
                    r_reach <= '0;
                    if (nx == 16'sd0 && ny == 16'sd0) begin
                        if (r_axis == AX_B2) begin
                            r_overlaps  <= 1'b1;
                            r_out_valid <= 1'b1;
                            r_state     <= ST_IDLE;
                        end else begin
                            r_axis <= r_axis + 2'd1;
                        end
                    end else begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    case (r_op) inside
                        OP_DY: r_sep <= {1'b0, dot_abs[48:0], 14'b0};
                        OP_A1Y, OP_A2Y, OP_B1Y, OP_B2Y: r_d <= dot_abs[31:0];
                        OP_HA1, OP_HA2, OP_HB1, OP_HB2:
                            r_reach <= r_reach + {1'b0, prod[63:0]};
                        default: r_dot <= prod[DotW-1:0];
                    endcase
                    if (r_op == OP_HB2) begin
                        r_state <= ST_CMP;
                    end else begin
                        r_op    <= r_op + 4'd1;
                        r_state <= ST_MUL;
                    end
                end
                ST_CMP: begin
                    if ({1'b0, r_sep} > r_reach) begin
                        r_overlaps  <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end else if (r_axis == AX_B2) begin
                        r_overlaps  <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= ST_CHECK;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

FILE: sim/oriented_box_overlap_checker.sv
// checker for the oriented box overlap test: predicts overlap results and compares
module oriented_box_overlap_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic               i_func,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic signed [15:0] i_axis1_x,
    input  logic signed [15:0] i_axis1_y,
    input  logic signed [15:0] i_axis2_x,
    input  logic signed [15:0] i_axis2_y,
    input  logic        [30:0] i_half_len1,
    input  logic        [30:0] i_half_len2,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_overlaps,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_tests,
    output int                 o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        longint cx, cy;
        longint a1x, a1y, a2x, a2y;
        longint h1, h2;
    } box_t;

    box_t    box_a;
    bit      overlap_q[$];

    // magnitude of a signed 64-bit value, as unsigned
    function automatic logic [63:0] abs64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] reach_of(box_t b, longint nx, longint ny);
        logic [63:0] d1, d2;
        d1 = abs64(b.a1x * nx + b.a1y * ny);
        d2 = abs64(b.a2x * nx + b.a2y * ny);
        return 64'(b.h1) * d1 + 64'(b.h2) * d2;
    endfunction

    // one candidate axis: gap means separated, zero axis is skipped
    function automatic bit axis_touch(box_t a, box_t b, longint nx, longint ny);
        logic [63:0] sep;
        if (nx == 0 && ny == 0) return 1'b1;
        sep = abs64((a.cx - b.cx) * nx + (a.cy - b.cy) * ny) << 14;
        return sep <= reach_of(a, nx, ny) + reach_of(b, nx, ny);
    endfunction

    function automatic bit boxes_overlap(box_t a, box_t b);
        return axis_touch(a, b, a.a1x, a.a1y) && axis_touch(a, b, a.a2x, a.a2y)
            && axis_touch(a, b, b.a1x, b.a1y) && axis_touch(a, b, b.a2x, b.a2y);
    endfunction

    always @(posedge i_clk) begin
        box_t b;
        bit exp_hit;
        if (!i_rst_n) begin
            box_a = '{default: 0};
            overlap_q.delete();
            o_errors <= 0;
            o_tests <= 0;
            o_hits <= 0;
            o_pending <= 0;
        end else begin
            // result side first so an item in the same cycle is not matched yet
            if (i_out_valid && !i_out_stall) begin
                if (overlap_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected result overlaps=%0b", i_overlaps);
                end else begin
                    exp_hit = overlap_q.pop_front();
                    o_tests <= o_tests + 1;
                    o_hits <= o_hits + exp_hit;
                    if (exp_hit !== i_overlaps) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("overlap mismatch: expected %0b got %0b", exp_hit, i_overlaps);
                    end
                end
            end
            // accepted item
            if (i_valid && !i_stall_in) begin
                b.cx = i_center_x;   b.cy = i_center_y;
                b.a1x = i_axis1_x;   b.a1y = i_axis1_y;
                b.a2x = i_axis2_x;   b.a2y = i_axis2_y;
                b.h1 = i_half_len1;  b.h2 = i_half_len2;
                if (!i_func) box_a = b;
                else overlap_q.push_back(boxes_overlap(box_a, b));
            end
            // results still owed by the block
            o_pending <= overlap_q.size();
        end
    end
endmodule

FILE: sim/oriented_box_overlap_test_tb.sv
// testbench top: stimulus, idling and verdict for the oriented box overlap test
module oriented_box_overlap_test_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumRandom = 1130;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               func = 1'b0;
    logic signed [31:0] center_x = '0, center_y = '0;
    logic signed [15:0] axis1_x = '0, axis1_y = '0, axis2_x = '0, axis2_y = '0;
    logic        [30:0] half_len1 = '0, half_len2 = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               overlaps;
    int                 errors, pending, tests, hits;
    bit                 quiet_tail = 0;
    bit                 long_hold = 0;

    oriented_box_overlap_test i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_func(func), .i_center_x(center_x), .i_center_y(center_y),
        .i_axis1_x(axis1_x), .i_axis1_y(axis1_y), .i_axis2_x(axis2_x),
        .i_axis2_y(axis2_y), .i_half_len1(half_len1), .i_half_len2(half_len2),
        .o_valid(out_valid), .i_stall(out_stall), .o_overlaps(overlaps)
    );

    oriented_box_overlap_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_stall_in(in_stall),
        .i_func(func), .i_center_x(center_x), .i_center_y(center_y),
        .i_axis1_x(axis1_x), .i_axis1_y(axis1_y), .i_axis2_x(axis2_x),
        .i_axis2_y(axis2_y), .i_half_len1(half_len1), .i_half_len2(half_len2),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_overlaps(overlaps),
        .o_errors(errors), .o_pending(pending), .o_tests(tests), .o_hits(hits)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // offer one item and hold it until accepted
    task automatic send_box(bit f, logic [31:0] cx, logic [31:0] cy,
                            logic [15:0] a1x, logic [15:0] a1y,
                            logic [15:0] a2x, logic [15:0] a2y,
                            logic [30:0] h1, logic [30:0] h2);
        func <= f;  center_x <= cx;  center_y <= cy;
        axis1_x <= a1x;  axis1_y <= a1y;  axis2_x <= a2x;  axis2_y <= a2y;
        half_len1 <= h1;  half_len2 <= h2;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // random gap between items
    task automatic sender_gap();
        int n;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            n = $urandom_range(1, 13);
            repeat (n) @(negedge clk);
        end
    endtask

    // mostly plausible boxes so all axes get exercised; some full-range noise
    task automatic send_random(bit f);
        logic [31:0] cx, cy;
        logic [15:0] ax[4];
        logic [30:0] h1, h2;
        int k;
        k = $urandom_range(0, 9);
        if (k < 7) begin
            cx = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            cy = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            foreach (ax[j]) ax[j] = 16'($signed($urandom_range(0, 32768)) - 16384);
            h1 = 31'($urandom_range(0, 1 << 21));
            h2 = 31'($urandom_range(0, 1 << 21));
            if ($urandom_range(0, 15) == 0) begin
                ax[0] = '0;  ax[1] = '0;
            end
        end else begin
            cx = $urandom();  cy = $urandom();
            foreach (ax[j]) ax[j] = 16'($urandom());
            h1 = 31'($urandom());  h2 = 31'($urandom());
        end
        send_box(f, cx, cy, ax[0], ax[1], ax[2], ax[3], h1, h2);
    endtask

    // receiver stalls in bursts, plus one long hold-off
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (long_hold) begin
                out_stall <= 1'b1;
                repeat (400) @(negedge clk);
                out_stall <= 1'b0;
                long_hold = 0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                n = $urandom_range(1, 13);
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // generous fixed limit
    initial begin
        #4ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int w;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // box B against the reset box A (a point at the origin)
        send_box(1, 0, 0, 16'sd16384, 0, 0, 16'sd16384, 31'd65536, 31'd65536);
        send_box(1, 32'sd200000, 0, 16'sd16384, 0, 0, 16'sd16384, 31'd65536, 31'd65536);
        // unit box A, touching and separated neighbors
        send_box(0, 0, 0, 16'sd16384, 0, 0, 16'sd16384, 31'd65536, 31'd65536);
        send_box(1, 32'sd131072, 0, 16'sd16384, 0, 0, 16'sd16384, 31'd65536, 31'd65536);
        send_box(1, 32'sd131073, 0, 16'sd16384, 0, 0, 16'sd16384, 31'd65536, 31'd65536);
        send_box(1, 0, 32'sd140000, 16'sd11585, 16'sd11585, -16'sd11585, 16'sd11585,
                 31'd65536, 31'd65536);
        // zero axes on B
        send_box(1, 32'sd100000, 0, 0, 0, 0, 0, 0, 0);
        // extremes everywhere
        send_box(0, 32'h80000000, 32'h7fffffff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                 31'h7fffffff, 31'h7fffffff);
        send_box(1, 32'h7fffffff, 32'h80000000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                 31'h7fffffff, 31'h7fffffff);
        send_box(1, 32'h7fffffff, 32'h80000000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                 0, 0);
        send_box(0, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                 31'h7fffffff, 0);
        send_box(1, 32'h7fffffff, 32'h7fffffff, 16'h0001, 16'hffff, 16'h8000, 16'h0000,
                 0, 31'h7fffffff);
        send_box(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_box(1, 0, 0, 0, 0, 0, 0, 0, 0);

        // long receiver hold while items keep coming
        long_hold = 1;
        for (int i = 0; i < 12; i++) send_random(1);

        for (int i = 0; i < NumRandom; i++) begin
            if (i == NumRandom / 2) begin
                // sender pause until the block has drained
                in_valid <= 1'b0;
                while (pending != 0) @(negedge clk);
            end
            if (i == NumRandom - 150) quiet_tail = 1;
            sender_gap();
            send_random($urandom_range(0, 3) != 0);
        end
        in_valid <= 1'b0;

        w = 0;
        while (pending != 0 && w < 100000) begin
            @(negedge clk);
            w++;
        end
        repeat (150) @(negedge clk);
        $display("ran %0d overlap tests (%0d overlapping, %0d separated)",
                 tests, hits, tests - hits);
        if (errors == 0 && pending == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
